>>> src/sgk_pkg.sv
// Shared types, constants and helpers of the signature kernel grid solver.
`default_nettype none
package sgk_pkg;

  localparam int unsigned MAX_ROWS = 1024;
  localparam int unsigned MAX_COLS = 1024;

  localparam int unsigned DimW = 11;
  localparam int unsigned CntW = 10;
  localparam int unsigned KW   = 48;
  localparam int unsigned CW   = 32;
  localparam int unsigned DW   = 34;
  localparam int unsigned PW   = 58;

  localparam logic signed [KW-1:0] ONE_Q32 = 48'sh0001_0000_0000;
  localparam logic signed [DW-1:0] ONE_Q24 = 34'sh0_0100_0000;
  localparam logic signed [KW-1:0] SAT_HI  = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [KW-1:0] SAT_LO  = 48'sh8000_0000_0000;

  typedef enum logic [1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic row0;
    logic col0;
    logic last;
  } ctl_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] maxv);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/sgk_cell.sv
// One cell of the row store chain: holds one kernel value of the previous row.
`default_nettype none
module sgk_cell
  import sgk_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic          sel_new_i,
  input  wire logic [KW-1:0] new_i,
  input  wire logic [KW-1:0] next_i,
  output logic      [KW-1:0] val_o
);

  logic [KW-1:0] val_q;
  logic [KW-1:0] val_d;

  always_comb begin
    val_d = sel_new_i ? new_i : next_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule
`default_nettype wire

>>> src/sgk_mul.sv
// Two-stage rounded multiply of a kernel value by (c - 1).
`default_nettype none
module sgk_mul
  import sgk_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic signed [KW-1:0] k_i,
  input  wire logic signed [DW-1:0] d_i,
  output logic signed      [PW-1:0] prod_o
);

  logic signed [65:0] pl_d;
  logic signed [65:0] ph_d;
  logic signed [65:0] pl_q;
  logic signed [65:0] ph_q;
  logic signed [82:0] p;
  logic signed [82:0] rnd;

  always_comb begin
    pl_d = k_i * $signed({1'b0, d_i[16:0]});
    ph_d = k_i * $signed(d_i[33:17]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q <= pl_d;
      ph_q <= ph_d;
    end
  end

  // round to nearest, ties away from zero
  always_comb begin
    p   = (83'(ph_q) <<< 17) + 83'(pl_q);
    rnd = p + 83'sd8388608 - (p[82] ? 83'sd1 : 83'sd0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_o <= rnd[81:24];
    end
  end

endmodule
`default_nettype wire

>>> src/signature_kernel_grid_solver_core.sv
// Top level of the signature kernel grid solver.
// Usage:
//   Increment products enter on in_valid_i / in_stall_o in row-major order,
//   one request per grid cell. Each request yields one result request on
//   out_valid_o / out_stall_i carrying kernel_value_o and last_of_grid_o,
//   the latter high on the final cell of a grid; the next request then
//   starts the next grid of the batch.
//   Throughput: one request per cycle while the output is not stalled, for every grid size.
//   The result is registered in the operand register, the two-stage
//   multiplier (the final add with saturation sits behind its second
//   stage) and the output register, in that order.
//   The previous row lives in a chain of MAX_COLS+1 cells that shifts once
//   per finished cell; the newest value enters at the cell chosen by
//   cols_in_use so the oldest needed value always sits near the head.
//   A stall on a valid output freezes the whole pipeline and raises in_stall_o.
//   cfg_we_i writes rows_in_use (index 0) or cols_in_use (index 1) and
//   restarts the grid; write only while the block is idle.
//   Reset: asynchronous, active low; both sizes reset to 1024, counters to
//   zero, no request held. The row store needs no clearing.
`default_nettype none
module signature_kernel_grid_solver_core
  import sgk_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [DimW-1:0]      cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic signed [CW-1:0] increment_product_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [KW-1:0]      kernel_value_o,
  output logic                      last_of_grid_o
);

  logic [DimW-1:0] rows_q, cols_q;
  logic [CntW-1:0] col_q, col_d, row_q, row_d;
  logic            adv, accept, complete;
  ctl_t            ctl_in, ctl1_q, ctl2_q, ctl3_q;
  logic            v1_q, v2_q, v3_q, ov_q;
  logic signed [DW-1:0] d1_q;
  logic signed [KW-1:0] diag_d, diag1_q;
  logic signed [PW-1:0] prod3;
  logic signed [KW-1:0] left_q, left_v, up_v, fsum;
  logic signed [59:0]   sum60;
  logic [1:0]           infl;
  logic [KW-1:0]        cell_val [MAX_COLS+1];
  logic [DimW-1:0]      col_p1;
  logic [DimW-1:0]      row_p1;

  assign adv        = !ov_q || !out_stall_i;
  assign accept     = in_valid_i && adv;
  assign complete   = v3_q && adv;
  assign in_stall_o = !adv;

  // grid position of the incoming request
  always_comb begin
    col_p1      = DimW'(col_q) + DimW'(1);
    row_p1      = DimW'(row_q) + DimW'(1);
    col_d       = col_q + CntW'(1);
    row_d       = row_q;
    ctl_in.row0 = (row_q == '0);
    ctl_in.col0 = (col_q == '0);
    ctl_in.last = 1'b0;
    if (col_p1 >= cols_q) begin
      col_d = '0;
      row_d = row_q + CntW'(1);
      if (row_p1 >= rows_q) begin
        row_d       = '0;
        ctl_in.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DimW'(MAX_ROWS);
      cols_q <= DimW'(MAX_COLS);
      col_q  <= '0;
      row_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ROWS: begin
          rows_q <= clamp_dim(cfg_data_i, DimW'(MAX_ROWS));
          col_q  <= '0;
          row_q  <= '0;
        end
        REG_COLS: begin
          cols_q <= clamp_dim(cfg_data_i, DimW'(MAX_COLS));
          col_q  <= '0;
          row_q  <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // diagonal: last completed value sits at cell = requests in flight,
  // or is the one finishing now
  always_comb begin
    infl = 2'(v1_q) + 2'(v2_q) + 2'(v3_q);
    if (ctl_in.col0 || ctl_in.row0) begin
      diag_d = ONE_Q32;
    end else begin
      case (infl)
        2'd0: diag_d = cell_val[0];
        2'd1: diag_d = cell_val[1];
        2'd2: diag_d = cell_val[2];
        default: diag_d = (cols_q == DimW'(2)) ? fsum : cell_val[3];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      ov_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl1_q  <= ctl_in;
      d1_q    <= $signed({{2{increment_product_i[CW-1]}}, increment_product_i}) - ONE_Q24;
      diag1_q <= diag_d;
      ctl2_q  <= ctl1_q;
      ctl3_q  <= ctl2_q;
    end
  end

  sgk_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (adv),
    .k_i    (diag1_q),
    .d_i    (d1_q),
    .prod_o (prod3)
  );

  always_comb begin
    left_v = ctl3_q.col0 ? ONE_Q32 : left_q;
    up_v   = ctl3_q.row0 ? ONE_Q32 : $signed(cell_val[1]);
    sum60  = 60'(left_v) + 60'(up_v) + 60'(prod3);
    if (sum60[59:47] == '0 || sum60[59:47] == '1) begin
      fsum = sum60[47:0];
    end else if (sum60[59]) begin
      fsum = SAT_LO;
    end else begin
      fsum = SAT_HI;
    end
  end

  always_ff @(posedge clk_i) begin
    if (complete) begin
      left_q <= fsum;
    end
    if (adv) begin
      kernel_value_o <= fsum;
      last_of_grid_o <= ctl3_q.last;
    end
  end

  for (genvar i = 0; i <= MAX_COLS; i++) begin : g_row
    logic [KW-1:0] next_v;
    if (i == MAX_COLS) begin : g_tail
      assign next_v = fsum;
    end else begin : g_mid
      assign next_v = cell_val[i+1];
    end
    sgk_cell u_cell (
      .clk_i     (clk_i),
      .en_i      (complete),
      .sel_new_i (cols_q == DimW'(i)),
      .new_i     (fsum),
      .next_i    (next_v),
      .val_o     (cell_val[i])
    );
  end

  assign out_valid_o = ov_q;

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    DimW'(col_q) < cols_q) else $error("column counter beyond grid width");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    DimW'(row_q) < rows_q) else $error("row counter beyond grid height");

  a_last_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !cfg_we_i && ctl_in.last |=> col_q == '0 && row_q == '0)
    else $error("grid did not restart after its last cell");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v1_q) else $error("accepted request lost at first stage");

endmodule
`default_nettype wire
